[src/dfd_pkg.sv]
// Shared types and constants of the debug frame deframer.
package dfd_pkg;

    // Header and frame layout.
    localparam logic [7:0] SYNC_FIRST_RESET  = 8'hFE;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'h7F;

    localparam int unsigned POS_W = 4;
    localparam logic [POS_W-1:0] POS_FIRST_BODY  = 4'd2;
    localparam logic [POS_W-1:0] POS_ID_HI       = 4'd2;
    localparam logic [POS_W-1:0] POS_ID_LO       = 4'd3;
    localparam logic [POS_W-1:0] POS_DIR         = 4'd4;
    localparam logic [POS_W-1:0] POS_CMD         = 4'd5;
    localparam logic [POS_W-1:0] POS_PARAM_FIRST = 4'd6;
    localparam logic [POS_W-1:0] POS_PARAM_LAST  = 4'd9;
    localparam logic [POS_W-1:0] POS_CHECKSUM    = 4'd10;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND = 1'b1;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    // Input item: one byte of the stream.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_end;
    } dfd_in_t;

    // Result item: one decoded frame.
    typedef struct packed {
        logic [15:0] device_id;
        logic [7:0]  direction;
        logic [7:0]  command;
        logic [31:0] parameter_res;
        logic        sum_ok;
    } dfd_out_t;

    // Operation handed from the classifier to the frame builder.
    typedef enum logic {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } dfd_kind_t;

    typedef struct packed {
        dfd_kind_t        kind;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;   // frame byte, or the checksum seed on a start
    } dfd_op_t;

endpackage

[src/dfd_front.sv]
// Byte classifier: hunts for the sync header and tags frame body bytes.
module dfd_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           byte_valid,
    output logic                           byte_ready,
    input  dfd_pkg::dfd_in_t               byte_item,
    input  logic                           cfg_we,
    input  logic [dfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    output logic                           op_valid,
    input  logic                           op_ready,
    output dfd_pkg::dfd_op_t               op_item
);
    import dfd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEAD,
        PH_BODY
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] index_reg, index_next;
    logic [7:0]       sync_first_reg, sync_first_next;
    logic [7:0]       sync_second_reg, sync_second_next;
    logic             accept;
    logic             emit;
    logic [7:0]       b;

    assign b          = byte_item.rx_byte;
    assign byte_ready = op_ready;
    assign accept     = byte_valid && byte_ready;
    assign op_valid   = accept && emit;

    always_comb
    begin
        phase_next       = phase_reg;
        index_next       = index_reg;
        sync_first_next  = sync_first_reg;
        sync_second_next = sync_second_reg;
        emit             = 1'b0;
        op_item.kind     = OP_DATA;
        op_item.pos      = index_reg;
        op_item.data     = b;

        case (phase_reg)
            PH_BODY:
            begin
                emit = 1'b1;
                if (index_reg >= POS_CHECKSUM)
                begin
                    phase_next = PH_IDLE;
                    index_next = '0;
                end
                else
                begin
                    index_next = index_reg + 1'b1;
                end
            end
            PH_HEAD:
            begin
                // The second header byte is checked first, so equal header
                // values still confirm a frame.
                if (b == sync_second_reg)
                begin
                    emit         = 1'b1;
                    op_item.kind = OP_START;
                    op_item.data = sync_first_reg + sync_second_reg;
                    phase_next   = PH_BODY;
                    index_next   = POS_FIRST_BODY;
                end
                else if (b == sync_first_reg)
                begin
                    phase_next = PH_HEAD;
                    index_next = 4'd1;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    index_next = '0;
                end
            end
            default:
            begin
                if (b == sync_first_reg)
                begin
                    phase_next = PH_HEAD;
                    index_next = 4'd1;
                end
                else
                begin
                    phase_next = PH_IDLE;
                    index_next = '0;
                end
            end
        endcase

        if (byte_item.buffer_end)
        begin
            phase_next = PH_IDLE;
            index_next = '0;
        end

        if (!accept)
        begin
            phase_next = phase_reg;
            index_next = index_reg;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_next  = cfg_data;
                CFG_SYNC_SECOND: sync_second_next = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            index_reg       <= '0;
            sync_first_reg  <= SYNC_FIRST_RESET;
            sync_second_reg <= SYNC_SECOND_RESET;
        end
        else
        begin
            phase_reg       <= phase_next;
            index_reg       <= index_next;
            sync_first_reg  <= sync_first_next;
            sync_second_reg <= sync_second_next;
        end
    end

endmodule

[src/dfd_queue.sv]
// Small register queue of classified operations between front and back.
module dfd_queue #(
    parameter int unsigned DEPTH = dfd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  dfd_pkg::dfd_op_t push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output dfd_pkg::dfd_op_t pop_item
);
    import dfd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    dfd_op_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[src/dfd_back.sv]
// Frame builder: gathers the fields and checksum and holds the decoded frame.
module dfd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_valid,
    output logic             op_ready,
    input  dfd_pkg::dfd_op_t op_item,
    output logic             frame_valid,
    input  logic             frame_ready,
    output dfd_pkg::dfd_out_t frame_item
);
    import dfd_pkg::*;

    logic [15:0] id_reg, id_next;
    logic [7:0]  dir_reg, dir_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [31:0] param_reg, param_next;
    logic [7:0]  sum_reg, sum_next;
    logic        out_valid_reg, out_valid_next;
    dfd_out_t    out_reg, out_next;
    logic        is_last;
    logic        take;

    assign is_last     = (op_item.kind == OP_DATA) && (op_item.pos == POS_CHECKSUM);
    assign op_ready    = !is_last || !out_valid_reg || frame_ready;
    assign take        = op_valid && op_ready;
    assign frame_valid = out_valid_reg;
    assign frame_item  = out_reg;

    always_comb
    begin
        id_next        = id_reg;
        dir_next       = dir_reg;
        cmd_next       = cmd_reg;
        param_next     = param_reg;
        sum_next       = sum_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !frame_ready;

        if (take)
        begin
            if (op_item.kind == OP_START)
            begin
                sum_next   = op_item.data;
                id_next    = '0;
                dir_next   = '0;
                cmd_next   = '0;
                param_next = '0;
            end
            else if (is_last)
            begin
                out_next.device_id     = id_reg;
                out_next.direction     = dir_reg;
                out_next.command       = cmd_reg;
                out_next.parameter_res = param_reg;
                out_next.sum_ok        = (sum_reg == op_item.data);
                out_valid_next         = 1'b1;
            end
            else
            begin
                sum_next = sum_reg + op_item.data;
                if (op_item.pos == POS_ID_HI || op_item.pos == POS_ID_LO)
                begin
                    id_next = {id_reg[7:0], op_item.data};
                end
                else if (op_item.pos == POS_DIR)
                begin
                    dir_next = op_item.data;
                end
                else if (op_item.pos == POS_CMD)
                begin
                    cmd_next = op_item.data;
                end
                else if (op_item.pos >= POS_PARAM_FIRST && op_item.pos <= POS_PARAM_LAST)
                begin
                    param_next = {param_reg[23:0], op_item.data};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        dir_reg   <= dir_next;
        cmd_reg   <= cmd_next;
        param_reg <= param_next;
        sum_reg   <= sum_next;
        out_reg   <= out_next;
    end

endmodule

[src/debug_frame_deframer_unit.sv]
// Top level of the debug frame deframer: classifier, operation queue and frame builder.
//
// The deframer takes one byte item per cycle while the operation queue has
// room and hunts for a two-byte sync header (sync_first, then sync_second,
// reset 0xFE and 0x7F). A repeated first header byte keeps the hunt armed.
// After the header it collects nine more bytes into an 11-byte frame and
// emits one result item holding the big-endian device id, the direction and
// command bytes, the big-endian 32-bit parameter and a flag that tells
// whether the 8-bit sum of the first ten bytes equals the checksum byte.
// Frames with a bad checksum are still emitted. An item with buffer_end set
// is processed and then returns the hunt to idle, so a partial frame is
// dropped. The sustained rate is one byte item per cycle while the queue is
// not full. A frame reaches the result port through the queue and then the
// output register: the classifier is combinational, so the checksum
// operation enters the queue when its byte is accepted and loads the output
// register once the back end takes it. The queue (QUEUE_DEPTH entries) lets
// the classifier keep taking bytes while a finished frame waits to be taken;
// only a full queue stalls the byte input. Configuration writes take effect
// on the next cycle and are expected only while the block is idle.
module debug_frame_deframer_unit #(
    parameter int unsigned QUEUE_DEPTH = dfd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            byte_valid,
    output logic                            byte_ready,
    input  dfd_pkg::dfd_in_t                byte_item,
    output logic                            frame_valid,
    input  logic                            frame_ready,
    output dfd_pkg::dfd_out_t               frame_item,
    input  logic                            cfg_we,
    input  logic [dfd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data
);
    import dfd_pkg::*;

    // Classified operations: header confirmations and tagged body bytes.
    logic    push_valid;
    logic    push_ready;
    dfd_op_t push_item;
    logic    pop_valid;
    logic    pop_ready;
    dfd_op_t pop_item;

    // The front end owns the hunt state and the header registers. It only
    // pushes an operation for a confirmed header or a frame body byte.
    dfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .op_valid   (push_valid),
        .op_ready   (push_ready),
        .op_item    (push_item)
    );

    dfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // The back end builds the fields and checksum and holds the finished
    // frame in its output register until it is taken.
    dfd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (pop_valid),
        .op_ready    (pop_ready),
        .op_item     (pop_item),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_item  (frame_item)
    );

endmodule
